@@ design/hufd_pkg.sv @@
// Shared types and constants for the Huffman tree-walk decoder.
package hufd_pkg;

    localparam int IDX_W   = 9;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int VB_W    = 4;
    localparam int CNT_W   = 32;
    localparam int MODE_W  = 2;
    localparam int TDATA_W = 48;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [VB_W-1:0] BYTE_BITS = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE_NODE = 2'd0,
        MODE_DECODE     = 2'd1,
        MODE_START      = 2'd2
    } mode_t;

    // Register index, taken from paddr[2]
    localparam logic REG_ORIGINAL_SIZE = 1'b0;
    localparam logic REG_ROOT_NODE     = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    // Input tdata layout, first field in the highest bits
    typedef struct packed {
        logic [VB_W-1:0]   valid_bits;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  right_child;
        logic [IDX_W-1:0]  left_child;
        logic [SYM_W-1:0]  node_symbol;
        logic              node_is_leaf;
        logic [IDX_W-1:0]  node_index;
    } in_data_t;

    typedef struct packed {
        logic accept;
        logic start_byte;
        logic rd_walk;
        logic rd_child;
        logic emit;
        logic bit_done;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_decode;
        logic bits_left;
        logic active;
        logic node_leaf;
        logic slot_free;
        logic pend_valid;
    } status_t;

endpackage

@@ design/huffman_tree_bit_decoder_top.sv @@
// Huffman tree-walk decoder: at most one node table read per cycle, up to two reads per bit.
// Node write, stream start and unused modes are taken in S_IDLE without leaving it.
// A data byte is walked one valid bit at a time through the single read port of the node
// table; the next item is taken once the last symbol is held.
// Reset (rst_n low, asynchronous) clears configuration, walk position and symbol count;
// the node table is not cleared and must be written before it is walked.
module huffman_tree_bit_decoder_top #(
    parameter int NODE_COUNT   = 512,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // node_index[8:0], node_is_leaf[9], node_symbol[17:10], left_child[26:18],
    // right_child[35:27], data_byte[43:36], valid_bits[47:44]
    input  logic [hufd_pkg::TDATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  logic [hufd_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // symbol[7:0]
    output logic [hufd_pkg::SYM_W-1:0]     m_tdata,
    output logic                           m_tlast,
    // stream_done[0]
    output logic                           m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hufd_pkg::PADDR_W-1:0]   paddr,
    input  logic [hufd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hufd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [hufd_pkg::CNT_W-1:0] original_size;
    logic [hufd_pkg::IDX_W-1:0] root_node;
    hufd_pkg::cmd_t             cmd;
    hufd_pkg::status_t          status;

    hufd_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .original_size (original_size),
        .root_node     (root_node)
    );

    hufd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hufd_dpath #(
        .NODE_COUNT   (NODE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .cmd           (cmd),
        .status        (status),
        .original_size (original_size),
        .root_node     (root_node),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule

@@ design/hufd_regs.sv @@
// APB configuration registers: original size and root node index.
module hufd_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hufd_pkg::PADDR_W-1:0]   paddr,
    input  logic [hufd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hufd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [hufd_pkg::CNT_W-1:0]     original_size,
    output logic [hufd_pkg::IDX_W-1:0]     root_node
);

    logic [hufd_pkg::CNT_W-1:0] original_size_reg, original_size_next;
    logic [hufd_pkg::IDX_W-1:0] root_node_reg, root_node_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        original_size_next = original_size_reg;
        root_node_next     = root_node_reg;
        if (wr_en)
        begin
            case (paddr[2])
                hufd_pkg::REG_ORIGINAL_SIZE: original_size_next = pwdata;
                hufd_pkg::REG_ROOT_NODE:     root_node_next = pwdata[hufd_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            hufd_pkg::REG_ORIGINAL_SIZE: prdata = original_size_reg;
            hufd_pkg::REG_ROOT_NODE:
                prdata = hufd_pkg::PDATA_W'(root_node_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            original_size_reg <= '0;
            root_node_reg     <= '0;
        end
        else
        begin
            original_size_reg <= original_size_next;
            root_node_reg     <= root_node_next;
        end
    end

    assign original_size = original_size_reg;
    assign root_node     = root_node_reg;

endmodule

@@ design/hufd_ctrl.sv @@
// Walk sequencer: steps through the bits of one byte and the node reads of each bit.
module hufd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hufd_pkg::status_t status,
    output hufd_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BIT   = 5'b00010,
        S_CUR   = 5'b00100,
        S_CHILD = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   can_emit;

    // A new symbol pushes the pending one out, so the output slot must be free
    assign can_emit = !status.pend_valid || status.slot_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_decode)
                    begin
                        cmd.start_byte = 1'b1;
                        state_next     = S_BIT;
                    end
                end
            end
            S_BIT:
            begin
                if (status.bits_left && status.active)
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_CUR;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CUR:
            begin
                if (status.node_leaf)
                begin
                    // leaf at the walk position: emit and stay at the root
                    if (can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.bit_done = 1'b1;
                        state_next   = S_BIT;
                    end
                end
                else
                begin
                    cmd.rd_child = 1'b1;
                    state_next   = S_CHILD;
                end
            end
            S_CHILD:
            begin
                if (status.node_leaf)
                begin
                    if (can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.bit_done = 1'b1;
                        state_next   = S_BIT;
                    end
                end
                else
                begin
                    cmd.bit_done = 1'b1;
                    state_next   = S_BIT;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/hufd_dpath.sv @@
// Datapath: node table, walk position, symbol count, pending and output registers.
module hufd_dpath #(
    parameter int NODE_COUNT   = 512,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [hufd_pkg::TDATA_W-1:0]   s_tdata,
    input  logic [hufd_pkg::MODE_W-1:0]    s_tuser,
    input  hufd_pkg::cmd_t                 cmd,
    output hufd_pkg::status_t              status,
    input  logic [hufd_pkg::CNT_W-1:0]     original_size,
    input  logic [hufd_pkg::IDX_W-1:0]     root_node,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hufd_pkg::SYM_W-1:0]     m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    hufd_pkg::in_data_t in_data;
    hufd_pkg::node_t    node_mem [NODE_COUNT];
    hufd_pkg::node_t    wr_node;
    hufd_pkg::node_t    rd_data_reg;
    hufd_pkg::node_t    cur_node;
    logic               rd_oor_reg;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [hufd_pkg::IDX_W-1:0] rd_idx;
    logic [hufd_pkg::IDX_W-1:0] child;
    logic               rd_in_range;

    logic [hufd_pkg::IDX_W-1:0]  walk_reg, walk_next;
    logic [hufd_pkg::CNT_W-1:0]  sw_reg, sw_next;
    logic [hufd_pkg::CNT_W-1:0]  sw_inc;
    logic [hufd_pkg::BYTE_W-1:0] shift_reg, shift_next;
    logic [hufd_pkg::VB_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [hufd_pkg::VB_W-1:0]   nbits_reg, nbits_next;
    logic [hufd_pkg::VB_W-1:0]   nbits_in;

    logic                        pend_valid_reg, pend_valid_next;
    logic [hufd_pkg::SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic                        pend_done_reg, pend_done_next;
    logic                        out_valid_reg, out_valid_next;
    logic [hufd_pkg::SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_done_reg, out_done_next;
    logic                        out_load;

    assign in_data = hufd_pkg::in_data_t'(s_tdata);

    // Node writes: drop indexes beyond the table, clamp symbols to the alphabet
    assign wr_en   = cmd.accept && (s_tuser == hufd_pkg::MODE_WRITE_NODE)
                     && (32'(in_data.node_index) < 32'(NODE_COUNT));
    assign wr_addr = AW'(in_data.node_index);
    always_comb
    begin
        wr_node.leaf  = in_data.node_is_leaf;
        wr_node.sym   = (32'(in_data.node_symbol) < 32'(SYMBOL_COUNT))
                        ? in_data.node_symbol : hufd_pkg::SYM_W'(SYMBOL_COUNT - 1);
        wr_node.left  = in_data.left_child;
        wr_node.right = in_data.right_child;
    end

    assign cur_node    = rd_oor_reg ? '0 : rd_data_reg;
    assign child       = shift_reg[hufd_pkg::BYTE_W-1] ? cur_node.right : cur_node.left;
    assign rd_en       = cmd.rd_walk || cmd.rd_child;
    assign rd_idx      = cmd.rd_child ? child : walk_reg;
    assign rd_addr     = AW'(rd_idx);
    assign rd_in_range = 32'(rd_idx) < 32'(NODE_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            node_mem[wr_addr] <= wr_node;
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
            rd_oor_reg  <= !rd_in_range;
        end
    end

    assign sw_inc   = sw_reg + 32'd1;
    assign nbits_in = ((in_data.valid_bits == '0) || (in_data.valid_bits > hufd_pkg::BYTE_BITS))
                      ? hufd_pkg::BYTE_BITS : in_data.valid_bits;
    assign out_load = (cmd.emit && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        walk_next       = walk_reg;
        sw_next         = sw_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        nbits_next      = nbits_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        if (cmd.accept && (s_tuser == hufd_pkg::MODE_START))
        begin
            walk_next = root_node;
            sw_next   = '0;
        end
        if (cmd.start_byte)
        begin
            shift_next   = in_data.data_byte;
            bit_cnt_next = '0;
            nbits_next   = nbits_in;
        end
        if (cmd.rd_child)
            walk_next = child;
        if (cmd.bit_done)
        begin
            shift_next   = {shift_reg[hufd_pkg::BYTE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 4'd1;
        end
        // The held symbol moves out; it is last only on flush
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = pend_sym_reg;
            out_last_next  = cmd.flush;
            out_done_next  = pend_done_reg;
        end
        if (cmd.emit)
        begin
            walk_next       = root_node;
            sw_next         = sw_inc;
            pend_valid_next = 1'b1;
            pend_sym_next   = cur_node.sym;
            pend_done_next  = (sw_inc == original_size);
        end
        if (cmd.flush)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            sw_reg         <= '0;
            bit_cnt_reg    <= '0;
            nbits_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            walk_reg       <= walk_next;
            sw_reg         <= sw_next;
            bit_cnt_reg    <= bit_cnt_next;
            nbits_reg      <= nbits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    always_comb
    begin
        status.is_decode  = (s_tuser == hufd_pkg::MODE_DECODE);
        status.bits_left  = (bit_cnt_reg != nbits_reg);
        status.active     = (sw_reg < original_size);
        status.node_leaf  = cur_node.leaf;
        status.slot_free  = !out_valid_reg || m_tready;
        status.pend_valid = pend_valid_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

@@ test/huffman_tree_bit_decoder_top_test.sv @@
// Stream testbench for the Huffman tree-walk decoder with an in-bench symbol predictor.
`timescale 1ns / 100ps

module huffman_tree_bit_decoder_top_test;

    localparam logic [hufd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 512;
    localparam int IDLE_TAIL   = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [hufd_pkg::SYM_W-1:0] sym;
        logic                       last;
        logic                       done;
    } sym_rec_t;

    class decode_scoreboard;
        hufd_pkg::node_t            node_mem [TABLE_DEPTH];
        logic [hufd_pkg::IDX_W-1:0] walk_at;
        logic [hufd_pkg::IDX_W-1:0] root_at;
        logic [hufd_pkg::CNT_W-1:0] sym_count;
        logic [hufd_pkg::CNT_W-1:0] size_limit;
        sym_rec_t                   pending_symbols [$];
        int                         fail_count;

        function new();
            walk_at    = '0;
            root_at    = '0;
            sym_count  = '0;
            size_limit = '0;
            fail_count = 0;
        endfunction

        function int pending();
            return pending_symbols.size();
        endfunction

        function void write_reg(logic idx, logic [hufd_pkg::PDATA_W-1:0] value);
            if (idx == hufd_pkg::REG_ORIGINAL_SIZE)
                size_limit = value;
            else
                root_at = value[hufd_pkg::IDX_W-1:0];
        endfunction

        // Leaf reached: count it, queue its symbol and return to the root
        function void push_symbol(logic [hufd_pkg::SYM_W-1:0] sym);
            sym_rec_t rec;
            sym_count++;
            rec.sym  = sym;
            rec.last = 1'b0;
            rec.done = (sym_count == size_limit);
            pending_symbols.insert(pending_symbols.size(), rec);
            walk_at = root_at;
        endfunction

        function void take_item(logic [hufd_pkg::MODE_W-1:0] mode, hufd_pkg::in_data_t d);
            hufd_pkg::node_t cur;
            int              nbits;
            int              emitted;
            logic            bitv;
            sym_rec_t        tail;
            case (mode)
                hufd_pkg::MODE_WRITE_NODE:
                    node_mem[d.node_index] = {d.node_is_leaf, d.node_symbol,
                                              d.left_child, d.right_child};
                hufd_pkg::MODE_START:
                begin
                    walk_at   = root_at;
                    sym_count = '0;
                end
                hufd_pkg::MODE_DECODE:
                begin
                    nbits = int'(d.valid_bits);
                    if (nbits == 0 || nbits > int'(hufd_pkg::BYTE_BITS))
                        nbits = int'(hufd_pkg::BYTE_BITS);
                    emitted = 0;
                    for (int b = 0; b < nbits && sym_count < size_limit; b++)
                    begin
                        bitv = d.data_byte[hufd_pkg::BYTE_W-1-b];
                        cur  = node_mem[walk_at];
                        // a leaf at the walk position emits without moving
                        if (cur.leaf)
                        begin
                            push_symbol(cur.sym);
                            emitted++;
                        end
                        else
                        begin
                            walk_at = bitv ? cur.right : cur.left;
                            cur     = node_mem[walk_at];
                            if (cur.leaf)
                            begin
                                push_symbol(cur.sym);
                                emitted++;
                            end
                        end
                    end
                    if (emitted > 0)
                    begin
                        tail = pending_symbols.pop_back();
                        tail.last = 1'b1;
                        pending_symbols.insert(pending_symbols.size(), tail);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_symbol(logic [hufd_pkg::SYM_W-1:0] sym, logic last, logic done);
            sym_rec_t want;
            if (pending_symbols.size() == 0)
            begin
                $display("%0t: unexpected symbol %02h last %0b done %0b",
                         $time, sym, last, done);
                fail_count++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (want.sym !== sym)
                begin
                    $display("%0t: symbol expected %02h actual %02h", $time, want.sym, sym);
                    fail_count++;
                end
                if (want.last !== last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                    fail_count++;
                end
                if (want.done !== done)
                begin
                    $display("%0t: stream_done expected %0b actual %0b",
                             $time, want.done, done);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [hufd_pkg::TDATA_W-1:0]     s_tdata;
    logic [hufd_pkg::MODE_W-1:0]      s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [hufd_pkg::SYM_W-1:0]       m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [hufd_pkg::PADDR_W-1:0]     paddr;
    logic [hufd_pkg::PDATA_W-1:0]     pwdata;
    logic [hufd_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;

    decode_scoreboard sb;
    bit               in_gaps;
    bit               out_gaps;
    int               rx_hold;
    int               cycles;

    huffman_tree_bit_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Observe transfers on both streams and enforce the cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_item(s_tuser, hufd_pkg::in_data_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_symbol(m_tdata, m_tlast, m_tuser);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_tready <= !(out_gaps && $urandom_range(0, 99) < 23);
        end
    end

    function automatic hufd_pkg::in_data_t random_fields();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return hufd_pkg::in_data_t'(r[hufd_pkg::TDATA_W-1:0]);
    endfunction

    task automatic send_item(input logic [hufd_pkg::MODE_W-1:0] mode,
                             input hufd_pkg::in_data_t d);
        @(negedge clk);
        while (in_gaps && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_decode(input logic [hufd_pkg::BYTE_W-1:0] data,
                               input logic [hufd_pkg::VB_W-1:0] nbits);
        hufd_pkg::in_data_t d;
        d            = random_fields();
        d.data_byte  = data;
        d.valid_bits = nbits;
        send_item(hufd_pkg::MODE_DECODE, d);
    endtask

    task automatic send_node(input int idx, input logic leaf,
                             input logic [hufd_pkg::SYM_W-1:0] sym,
                             input int left, input int right);
        hufd_pkg::in_data_t d;
        d              = random_fields();
        d.node_index   = hufd_pkg::IDX_W'(idx);
        d.node_is_leaf = leaf;
        d.node_symbol  = sym;
        d.left_child   = hufd_pkg::IDX_W'(left);
        d.right_child  = hufd_pkg::IDX_W'(right);
        send_item(hufd_pkg::MODE_WRITE_NODE, d);
    endtask

    // Hold the input until all symbols are out and the block has gone quiet
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (IDLE_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [hufd_pkg::PDATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random full binary tree in nodes base .. base+2*nleaves-2, root at the top index
    task automatic build_tree(input int base, input int nleaves,
                              output logic [hufd_pkg::IDX_W-1:0] root);
        int pool [$];
        int next;
        int a;
        int b;
        int pos;
        for (int i = 0; i < nleaves; i++)
        begin
            send_node(base + i, 1'b1, 8'($urandom), $urandom_range(0, 511),
                      $urandom_range(0, 511));
            pool.insert(pool.size(), base + i);
        end
        next = base + nleaves;
        while (pool.size() > 1)
        begin
            pos = $urandom_range(0, pool.size() - 1);
            a   = pool[pos];
            pool.delete(pos);
            pos = $urandom_range(0, pool.size() - 1);
            b   = pool[pos];
            pool.delete(pos);
            send_node(next, 1'b0, 8'($urandom), a, b);
            pool.insert(pool.size(), next);
            next++;
        end
        root = hufd_pkg::IDX_W'(pool[0]);
    endtask

    initial
    begin
        logic [hufd_pkg::IDX_W-1:0] root;
        logic [hufd_pkg::IDX_W-1:0] root_b;
        logic [hufd_pkg::CNT_W-1:0] limit_val;
        int                         nleaves;
        int                         base;
        int                         pick;

        sb       = new();
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        rx_hold  = 0;
        cycles   = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Size zero after reset: nothing comes out
        send_decode(8'hA5, 4'd8);

        // Root that is a leaf: one symbol per bit, valid_bits 0 and above 8 mean all 8
        send_node(0, 1'b1, 8'hFF, 0, 0);
        write_reg(hufd_pkg::REG_ORIGINAL_SIZE, 32'hFFFF_FFFF);
        write_reg(hufd_pkg::REG_ROOT_NODE, '0);
        send_item(hufd_pkg::MODE_START, random_fields());
        send_decode(8'h00, 4'd8);
        send_decode(8'hFF, 4'd0);
        send_decode(8'h5A, 4'd15);
        send_decode(8'hC3, 4'd9);
        send_decode(8'h80, 4'd1);

        // Tree at the top of the table, short stream that runs out
        build_tree(501, 6, root);
        build_tree(300, 5, root_b);
        write_reg(hufd_pkg::REG_ROOT_NODE, root);
        write_reg(hufd_pkg::REG_ORIGINAL_SIZE, 32'd5);
        send_item(hufd_pkg::MODE_START, random_fields());
        send_decode(8'hA5, 4'd8);
        send_decode(8'h3C, 4'd8);
        send_decode(8'hFF, 4'd8);
        send_decode(8'h0F, 4'd8);
        send_item(MODE_UNUSED, random_fields());
        send_decode(8'h00, 4'd8);
        send_item(hufd_pkg::MODE_START, random_fields());
        send_decode(8'h5A, 4'd3);

        // Move the root mid-stream: the walk finishes in the old tree first
        write_reg(hufd_pkg::REG_ORIGINAL_SIZE, 32'hFFFF_FFFF);
        write_reg(hufd_pkg::REG_ROOT_NODE, root_b);
        send_decode(8'hFF, 4'd8);
        send_decode(8'h00, 4'd8);
        send_decode(8'h96, 4'd7);

        write_reg(hufd_pkg::REG_ORIGINAL_SIZE, '0);
        send_item(hufd_pkg::MODE_START, random_fields());
        send_decode(8'hFF, 4'd8);

        // Random phases, each with a fresh tree and its own settings
        for (int p = 0; p < 5; p++)
        begin
            nleaves = $urandom_range(2, 5);
            base    = $urandom_range(0, TABLE_DEPTH - 1 - (2 * nleaves - 2));
            build_tree(base, nleaves, root);
            case (p)
                1: limit_val = $urandom_range(3, 30);
                3: limit_val = 32'hFFFF_FFFF;
                4: limit_val = 32'd1;
                default: limit_val = $urandom;
            endcase
            write_reg(hufd_pkg::REG_ROOT_NODE, root);
            write_reg(hufd_pkg::REG_ORIGINAL_SIZE, limit_val);
            in_gaps  = (p != 3);
            out_gaps = (p != 3);
            if (p == 2)
                rx_hold = HOLD_CYCLES;
            send_item(hufd_pkg::MODE_START, random_fields());
            for (int k = 0; k < 8; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_decode(8'($urandom), 4'($urandom_range(1, 8)));
                else if (pick < 85)
                    send_decode(8'($urandom), 4'($urandom_range(0, 15)));
                else if (pick < 91)
                    send_item(hufd_pkg::MODE_START, random_fields());
                else if (pick < 95)
                    send_item(MODE_UNUSED, random_fields());
                else
                    // turn a node of the live tree into a leaf so walks stay on written nodes
                    send_node($urandom_range(base, base + 2 * nleaves - 2), 1'b1,
                              8'($urandom), $urandom_range(0, 511), $urandom_range(0, 511));
            end
            wait_idle();
        end

        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        wait_idle();
        if (sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/hufd_pkg.sv
design/hufd_regs.sv
design/hufd_ctrl.sv
design/hufd_dpath.sv
design/huffman_tree_bit_decoder_top.sv
test/huffman_tree_bit_decoder_top_test.sv
